[src/assert_macros.svh]
// Assertion macros shared by the RTL of the fault-code log.
// Depends on nothing; a user provides clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define FCLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define FCLT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/fclt_pkg.sv]
// Types and constants of the fault-code log table.
// Used by fault_code_log_table; depends on nothing.
package fclt_pkg;

  // Request function codes
  localparam logic [1:0] FUNC_REPORT = 2'd0;
  localparam logic [1:0] FUNC_READ   = 2'd1;
  localparam logic [1:0] FUNC_COUNT  = 2'd2;
  localparam logic [1:0] FUNC_CLEAR  = 2'd3;

  // Occurrence count saturates here
  localparam logic [7:0] OCC_MAX = 8'hFF;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] fault_code;
    logic [4:0]  entry_index;
    logic [15:0] now_seconds;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  slot;
    logic [15:0] code_out;
    logic [7:0]  occurrences;
    logic [15:0] first_seen;
    logic [5:0]  entries_used;
  } out_item_t;

  // One log entry as held in memory
  typedef struct packed {
    logic [15:0] code;
    logic [7:0]  occ;
    logic [15:0] seen;
  } entry_t;

endpackage

[src/fclt_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; no package needed.
module fclt_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/fault_code_log_table.sv]
// Fault-code log table: sequential search over a memory of log entries.
// Depends on fclt_pkg, fclt_ram and assert_macros.svh.
//
// Usage:
//   Requests enter on in_valid/in_stall as an in_item_t; one result per request
//   leaves on out_valid/out_stall as an out_item_t. Both sides transfer when
//   valid is high and stall is low.
//   A report (func 0) scans the filled slots one per cycle, one memory read per
//   slot, then updates the hit or appends. The result is held in S_DONE and
//   loaded into the output register when that is free; the next request is
//   taken once the block is back in S_IDLE. Read entry goes through S_READ to
//   S_DONE; read count and clear go straight to S_DONE.
//   One request is worked on at a time; the result register lets the next
//   request in while the previous result is still stalled at the output.
//   If the receiver stalls, the finished result waits in a holding register and
//   no new request is taken until it moves on.
//   Reset empties the log at once: per-entry valid bits are cleared, so slots
//   never written read back as zero. No clearing pass is needed.
`include "assert_macros.svh"

module fault_code_log_table #(
  parameter int LOG_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fclt_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output fclt_pkg::out_item_t out_item
);

  import fclt_pkg::*;

  localparam int IDX_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int CNT_W = $clog2(LOG_DEPTH + 1);
  localparam int ENT_W = $bits(entry_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_READ,
    S_DONE
  } state_t;

  state_t                 state_r, state_nxt;
  in_item_t               req_r, req_nxt;
  logic [CNT_W-1:0]       scan_r, scan_nxt;
  logic [CNT_W-1:0]       fill_r, fill_nxt;
  logic [LOG_DEPTH-1:0]   valid_r, valid_nxt;
  out_item_t              res_r, res_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_item_r, out_item_nxt;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [IDX_W-1:0]       ram_raddr;
  entry_t                 ram_wdata;
  logic [ENT_W-1:0]       ram_rdata;

  entry_t                 ent_raw;
  entry_t                 scan_ent;
  entry_t                 read_ent;
  logic [CNT_W-1:0]       scan_plus;
  logic [IDX_W-1:0]       scan_idx;
  logic [8:0]             scan_ext;
  logic [8:0]             fill_ext;
  logic [8:0]             fill_nxt_ext;
  logic [8:0]             in_idx_ext;
  logic [8:0]             req_idx_ext;
  logic [IDX_W-1:0]       req_idx;
  logic                   req_in_range;
  logic                   scan_hit;
  logic                   scan_last;
  logic                   log_full;
  logic [IDX_W-1:0]       append_idx;
  logic                   out_free;

  fclt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (LOG_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Index and width helpers
  assign ent_raw      = entry_t'(ram_rdata);
  assign scan_plus    = scan_r + CNT_W'(1);
  assign scan_idx     = scan_r[IDX_W-1:0];
  assign scan_ext     = 9'(scan_r);
  assign fill_ext     = 9'(fill_r);
  assign fill_nxt_ext = 9'(fill_nxt);
  assign in_idx_ext   = 9'(in_item.entry_index);
  assign req_idx_ext  = 9'(req_r.entry_index);
  assign req_idx      = req_idx_ext[IDX_W-1:0];
  assign req_in_range = req_idx_ext < 9'(LOG_DEPTH);
  assign log_full     = fill_r == CNT_W'(LOG_DEPTH);
  assign append_idx   = log_full ? '0 : fill_r[IDX_W-1:0];
  assign out_free     = !out_valid_r || !out_stall;

  // Entries never written since reset or clear read as zero
  assign scan_ent  = valid_r[scan_idx] ? ent_raw : '0;
  assign read_ent  = (req_in_range && valid_r[req_idx]) ? ent_raw : '0;
  assign scan_hit  = (scan_r < fill_r) && (scan_ent.code == req_r.fault_code);
  assign scan_last = scan_plus >= fill_r;

  // Sequencer: accept, scan or read, update, hand off result
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    scan_nxt      = scan_r;
    fill_nxt      = fill_r;
    valid_nxt     = valid_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    ram_we        = 1'b0;
    ram_waddr     = scan_idx;
    ram_wdata     = scan_ent;
    ram_raddr     = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt  = in_item;
          scan_nxt = '0;
          res_nxt  = '0;
          res_nxt.entries_used = fill_ext[5:0];
          case (in_item.func)
            FUNC_REPORT: begin
              ram_raddr = '0;
              state_nxt = S_SEARCH;
            end
            FUNC_READ: begin
              ram_raddr = in_idx_ext[IDX_W-1:0];
              state_nxt = S_READ;
            end
            FUNC_CLEAR: begin
              fill_nxt  = '0;
              valid_nxt = '0;
              state_nxt = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_SEARCH: begin
        ram_raddr = scan_plus[IDX_W-1:0];
        scan_nxt  = scan_plus;
        if (scan_hit) begin
          // Known code: bump the count up to OCC_MAX, keep code and first-seen time
          ram_we    = 1'b1;
          ram_waddr = scan_idx;
          ram_wdata = scan_ent;
          if (scan_ent.occ != OCC_MAX) begin
            ram_wdata.occ = scan_ent.occ + 8'd1;
          end
          res_nxt.slot         = scan_ext[4:0];
          res_nxt.code_out     = ram_wdata.code;
          res_nxt.occurrences  = ram_wdata.occ;
          res_nxt.first_seen   = ram_wdata.seen;
          res_nxt.entries_used = fill_ext[5:0];
          state_nxt            = S_DONE;
        end else if (scan_last) begin
          // New code: append, or overwrite slot 0 when full
          ram_we         = 1'b1;
          ram_waddr      = append_idx;
          ram_wdata.code = req_r.fault_code;
          ram_wdata.occ  = 8'd1;
          ram_wdata.seen = req_r.now_seconds;
          valid_nxt[append_idx] = 1'b1;
          if (!log_full) begin
            fill_nxt = fill_r + CNT_W'(1);
          end
          res_nxt.slot         = 5'(append_idx);
          res_nxt.code_out     = ram_wdata.code;
          res_nxt.occurrences  = ram_wdata.occ;
          res_nxt.first_seen   = ram_wdata.seen;
          res_nxt.entries_used = fill_nxt_ext[5:0];
          state_nxt            = S_DONE;
        end
      end

      S_READ: begin
        res_nxt.slot         = req_r.entry_index;
        res_nxt.code_out     = read_ent.code;
        res_nxt.occurrences  = read_ent.occ;
        res_nxt.first_seen   = read_ent.seen;
        res_nxt.entries_used = fill_ext[5:0];
        state_nxt            = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, log control and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r      <= req_nxt;
    scan_r     <= scan_nxt;
    res_r      <= res_nxt;
    out_item_r <= out_item_nxt;
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Checks
  `FCLT_ASSERT(a_fill_bound, fill_r <= CNT_W'(LOG_DEPTH), "fill count beyond log depth")
  `FCLT_ASSERT(a_valid_fill, $countones(valid_r) == int'(fill_r), "valid bits disagree with fill")
  `FCLT_ASSERT(a_clear_empty, (in_valid && !in_stall && in_item.func == FUNC_CLEAR) |=> (fill_r == '0), "clear left entries")
  `FCLT_ASSERT(a_result_src, $rose(out_valid_r) |-> $past(state_r == S_DONE), "result without finished request")
  `FCLT_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE && !out_valid_r), "reset did not idle block")

endmodule

[dv/tb_fault_code_log_table.sv]
`timescale 1ns / 1ps
// Testbench for fault_code_log_table: directed and random requests with random idling,
// each result checked against an in-bench model of the log. Depends on fclt_pkg and the RTL.
module tb_fault_code_log_table;
  import fclt_pkg::*;

  localparam int LOG_DEPTH    = 32;
  localparam int NUM_ITEMS    = 1300;
  localparam int TAIL_ITEMS   = 150;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  fault_code_log_table #(.LOG_DEPTH(LOG_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // Model copy of the log
  logic [15:0] log_code [LOG_DEPTH];
  logic [7:0]  log_occ  [LOG_DEPTH];
  logic [15:0] log_seen [LOG_DEPTH];
  int          log_fill;

  in_item_t  req_q[$];
  out_item_t expect_q[$];
  int        req_total = 0;
  int        req_taken = 0;
  int        errors = 0;
  int        cycles = 0;
  int        idle_left = 0;
  int        stall_left = 0;
  logic      tail_phase = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void log_wipe();
    for (int i = 0; i < LOG_DEPTH; i++) begin
      log_code[i] = '0;
      log_occ[i]  = '0;
      log_seen[i] = '0;
    end
    log_fill = 0;
  endfunction

  // Apply one request to the model log and return the result it should give
  function automatic out_item_t log_apply(in_item_t r);
    out_item_t o;
    int        hit;
    bit        found;
    o = '0;
    hit = 0;
    found = 1'b0;
    case (r.func)
      FUNC_REPORT: begin
        // lowest matching filled slot wins
        for (int i = 0; i < log_fill; i++) begin
          if (!found && log_code[i] == r.fault_code) begin
            found = 1'b1;
            hit = i;
          end
        end
        if (found) begin
          if (log_occ[hit] != OCC_MAX) log_occ[hit] = log_occ[hit] + 8'd1;
        end else begin
          // full log: slot 0 is overwritten, fill stays
          if (log_fill < LOG_DEPTH) begin
            hit = log_fill;
            log_fill++;
          end else begin
            hit = 0;
          end
          log_code[hit] = r.fault_code;
          log_occ[hit]  = 8'd1;
          log_seen[hit] = r.now_seconds;
        end
        o.slot        = hit[4:0];
        o.code_out    = log_code[hit];
        o.occurrences = log_occ[hit];
        o.first_seen  = log_seen[hit];
      end
      FUNC_READ: begin
        o.slot        = r.entry_index;
        o.code_out    = log_code[r.entry_index];
        o.occurrences = log_occ[r.entry_index];
        o.first_seen  = log_seen[r.entry_index];
      end
      default: ;
    endcase
    o.entries_used = log_fill[5:0];
    if (r.func == FUNC_CLEAR) log_wipe();
    return o;
  endfunction

  task automatic queue_req(input logic [1:0] f, input logic [15:0] code,
                           input logic [4:0] idx, input logic [15:0] now);
    in_item_t r;
    r.func        = f;
    r.fault_code  = code;
    r.entry_index = idx;
    r.now_seconds = now;
    req_q.push_back(r);
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got)
      $display("%0t ns: mismatch on %s: expected %0h actual %0h", $time, name, want, got);
  endtask

  // Request driver: bursts of idle cycles, none in the tail
  always @(posedge clk) begin : drive_requests
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expect_q.push_back(log_apply(in_item));
        req_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (req_q.size() != 0 && !tail_phase && $urandom_range(0, 7) == 0) begin
          idle_left = $urandom_range(0, 4);
          in_valid <= 1'b0;
        end else if (req_q.size() != 0) begin
          in_item  <= req_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      tail_phase <= (req_q.size() < TAIL_ITEMS);
    end
  end

  // Result monitor and stall generator
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expect_q.size() == 0) begin
          errors++;
          $display("%0t ns: result with no request outstanding: expected none actual %h",
                   $time, out_item);
        end else begin
          want = expect_q.pop_front();
          if (want !== out_item) begin
            errors++;
            compare_field("slot", 16'(want.slot), 16'(out_item.slot));
            compare_field("code_out", want.code_out, out_item.code_out);
            compare_field("occurrences", 16'(want.occurrences), 16'(out_item.occurrences));
            compare_field("first_seen", want.first_seen, out_item.first_seen);
            compare_field("entries_used", 16'(want.entries_used), 16'(out_item.entries_used));
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 4);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_fault_code_log_table: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    logic [15:0] pool [48];
    logic [15:0] pick;
    int          pool_n;
    int          seg_len;
    int          roll;
    bit          hammered;
    hammered = 1'b0;
    log_wipe();

    // Directed: empty log, extreme codes and times, duplicates, reads above fill, clears
    queue_req(FUNC_COUNT, 16'($urandom), 5'($urandom), 16'($urandom));
    queue_req(FUNC_READ, 16'h0000, 5'd0, 16'h0000);
    queue_req(FUNC_READ, 16'hFFFF, 5'd31, 16'hFFFF);
    queue_req(FUNC_CLEAR, 16'($urandom), 5'($urandom), 16'($urandom));
    queue_req(FUNC_REPORT, 16'h0000, 5'd0, 16'h0000);
    queue_req(FUNC_REPORT, 16'hFFFF, 5'd31, 16'hFFFF);
    queue_req(FUNC_REPORT, 16'h0000, 5'($urandom), 16'h1234);
    queue_req(FUNC_REPORT, 16'hFFFF, 5'($urandom), 16'h0000);
    queue_req(FUNC_REPORT, 16'hA5C3, 5'd0, 16'h8001);
    queue_req(FUNC_READ, 16'($urandom), 5'd1, 16'($urandom));
    queue_req(FUNC_READ, 16'($urandom), 5'd2, 16'($urandom));
    queue_req(FUNC_READ, 16'($urandom), 5'd3, 16'($urandom));
    queue_req(FUNC_COUNT, 16'($urandom), 5'($urandom), 16'($urandom));
    queue_req(FUNC_CLEAR, 16'($urandom), 5'($urandom), 16'($urandom));
    queue_req(FUNC_READ, 16'($urandom), 5'd0, 16'($urandom));
    queue_req(FUNC_COUNT, 16'($urandom), 5'($urandom), 16'($urandom));
    // code 0 after a clear must append, not match the zeroed slots
    queue_req(FUNC_REPORT, 16'h0000, 5'($urandom), 16'h7FFF);
    queue_req(FUNC_REPORT, 16'h5A3C, 5'($urandom), 16'($urandom));
    queue_req(FUNC_READ, 16'($urandom), 5'd0, 16'($urandom));
    queue_req(FUNC_CLEAR, 16'($urandom), 5'($urandom), 16'($urandom));

    // Random: segments over a code pool; big pools fill the log and wrap slot 0
    while (req_q.size() < NUM_ITEMS) begin
      if (!hammered && req_q.size() > 400) begin
        // one code reported often enough to saturate its count
        hammered = 1'b1;
        pick = 16'($urandom);
        for (int n = 0; n < 300; n++) begin
          if ($urandom_range(0, 19) != 0)
            queue_req(FUNC_REPORT, pick, 5'($urandom), 16'($urandom));
          else
            queue_req(FUNC_READ, 16'($urandom), 5'($urandom), 16'($urandom));
        end
      end else begin
        pool_n = $urandom_range(1, 48);
        for (int n = 0; n < pool_n; n++) begin
          roll = $urandom_range(0, 15);
          pool[n] = (roll == 0) ? 16'h0000 : (roll == 1) ? 16'hFFFF : 16'($urandom);
        end
        seg_len = $urandom_range(20, 120);
        for (int n = 0; n < seg_len; n++) begin
          roll = $urandom_range(0, 99);
          if (roll < 65)
            queue_req(FUNC_REPORT, pool[$urandom_range(0, pool_n - 1)], 5'($urandom),
                      16'($urandom));
          else if (roll < 72)
            queue_req(FUNC_REPORT, 16'($urandom), 5'($urandom), 16'($urandom));
          else if (roll < 88)
            queue_req(FUNC_READ, 16'($urandom), 5'($urandom), 16'($urandom));
          else if (roll < 98)
            queue_req(FUNC_COUNT, 16'($urandom), 5'($urandom), 16'($urandom));
          else
            queue_req(FUNC_CLEAR, 16'($urandom), 5'($urandom), 16'($urandom));
        end
        if ($urandom_range(0, 1) == 0)
          queue_req(FUNC_CLEAR, 16'($urandom), 5'($urandom), 16'($urandom));
      end
    end
    req_total = req_q.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: every request taken and every result seen
    while (req_taken != req_total || expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && expect_q.size() == 0) begin
      $display("tb_fault_code_log_table: PASS");
    end else begin
      $display("tb_fault_code_log_table: FAIL");
    end
    $finish;
  end

endmodule
